// ===== hw/rtl/l4lb_pkg.sv =====
// l4lb_pkg: shared types, codes and constants of the l4 vip load balancer
// no dependencies; imported by every module of the block except l4lb_ram
`default_nettype none

package l4lb_pkg;

  // default sizes of the tables
  localparam int VIP_ENTRIES_DEF = 128;
  localparam int BACKENDS_DEF    = 8;

  // operation codes
  localparam logic [1:0] OP_PACKET   = 2'd0;
  localparam logic [1:0] OP_WRITE_VIP = 2'd1;
  localparam logic [1:0] OP_WRITE_BE = 2'd2;

  // verdict codes
  localparam logic [1:0] V_PASS  = 2'd0;
  localparam logic [1:0] V_TX    = 2'd1;
  localparam logic [1:0] V_DROP  = 2'd2;
  localparam logic [1:0] V_WRITE = 2'd3;

  // header constants
  localparam logic [15:0] TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] LEN_ETH     = 16'd14;
  localparam logic [15:0] LEN_ETH_IP  = 16'd34;
  localparam logic [15:0] LEN_TCP_MIN = 16'd54;
  localparam logic [15:0] LEN_UDP_MIN = 16'd42;

  // algorithm code for round robin
  localparam logic [1:0] ALGO_RR = 2'd0;

  // table entry widths
  localparam int VIP_W  = 63;
  localparam int BE_W   = 49;
  localparam int MAC_W  = 48;
  localparam int MOD_STEPS = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [6:0]  table_index;
    logic [2:0]  backend_slot;
    logic [47:0] entry_mac;
    logic [6:0]  entry_control;
  } l4lb_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [47:0] new_dst_mac;
    logic [31:0] new_dst_ip;
    logic [15:0] new_dest_port;
    logic [2:0]  chosen_backend;
    logic [31:0] received_count;
    logic [31:0] sent_count;
    logic [31:0] dropped_count;
  } l4lb_out_t;

  // vip entry as stored in memory
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  proto;
    logic [3:0]  count;
    logic [1:0]  algo;
  } l4lb_vip_t;

  // backend address entry as stored in memory
  typedef struct packed {
    logic        enabled;
    logic [31:0] addr;
    logic [15:0] port;
  } l4lb_be_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic mstart;
    logic mstep;
    logic bread;
    logic bdata;
    logic finish;
  } l4lb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic match;
    logic scan_end;
    logic count_zero;
    logic mod_last;
    logic idx_bad;
  } l4lb_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/l4lb_ram.sv =====
// l4lb_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module l4lb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/l4lb_ctrl.sv =====
// l4lb_ctrl: sequencing state machine of the load balancer
// depends on l4lb_pkg
`default_nettype none

module l4lb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output l4lb_pkg::l4lb_cmd_t       cmd,
  input  wire l4lb_pkg::l4lb_stat_t st
);

  import l4lb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MSTART, S_MOD, S_BREAD, S_BDATA, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = st.need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.match) state_nxt = S_MSTART;
        else if (st.scan_end) state_nxt = S_DONE;
      end
      S_MSTART: begin
        cmd.mstart = 1'b1;
        state_nxt = st.count_zero ? S_DONE : S_MOD;
      end
      S_MOD: begin
        cmd.mstep = 1'b1;
        if (st.mod_last) state_nxt = S_BREAD;
      end
      S_BREAD: begin
        cmd.bread = 1'b1;
        state_nxt = st.idx_bad ? S_DONE : S_BDATA;
      end
      S_BDATA: begin
        cmd.bdata = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/l4lb_dp.sv =====
// l4lb_dp: tables, vip scan, modulo unit, counters and result register
// depends on l4lb_pkg and l4lb_ram
`default_nettype none

module l4lb_dp #(
  parameter int VIP_ENTRIES      = l4lb_pkg::VIP_ENTRIES_DEF,
  parameter int BACKENDS_PER_VIP = l4lb_pkg::BACKENDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire l4lb_pkg::l4lb_in_t   in_data,
  input  wire l4lb_pkg::l4lb_cmd_t  cmd,
  output l4lb_pkg::l4lb_stat_t      st,
  output logic                      out_valid,
  output l4lb_pkg::l4lb_out_t       out_data
);

  import l4lb_pkg::*;

  localparam int BDEPTH = VIP_ENTRIES * BACKENDS_PER_VIP;
  localparam int VAW = (VIP_ENTRIES > 1) ? $clog2(VIP_ENTRIES) : 1;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int SCW = $clog2(VIP_ENTRIES + 1);
  localparam int STW = $clog2(MOD_STEPS);

  // latched item
  l4lb_in_t    item_r;
  logic [1:0]  verdict_r;

  // clearing pass
  logic [BAW-1:0] clr_r;

  // scan state
  logic [SCW-1:0] scan_addr_r;
  logic           rvalid_r;
  logic [VAW-1:0] cmp_idx_r;
  logic [VAW-1:0] hit_r;
  logic [3:0]     count_r;
  logic [1:0]     algo_r;

  // modulo unit
  logic [31:0]    div_r;
  logic [3:0]     rem_r;
  logic [STW-1:0] step_r;
  logic [31:0]    rr_r;

  // backend result
  logic [47:0] mac_r;
  logic [31:0] ip_r;
  logic [15:0] port_r;
  logic [2:0]  chosen_r;

  // counters
  logic [31:0] rx_r, tx_r, drop_r;

  // memory ports
  logic           vip_we, vip_re, be_we, be_re;
  logic [VAW-1:0] vip_waddr, vip_raddr;
  logic [BAW-1:0] be_waddr, be_raddr;
  l4lb_vip_t      vip_wdata, vip_rdata;
  l4lb_be_t       be_wdata, be_rdata;
  logic [MAC_W-1:0] mac_wdata, mac_rdata;

  // header checks on the incoming item
  logic       early_scan;
  logic [1:0] early_verdict;
  always_comb begin
    early_scan = 1'b0;
    early_verdict = V_PASS;
    if (in_data.operation != OP_PACKET) begin
      early_verdict = V_WRITE;
    end else if (in_data.frame_length < LEN_ETH) begin
      early_verdict = V_DROP;
    end else if (in_data.ether_type != TYPE_IPV4) begin
      early_verdict = V_PASS;
    end else if (in_data.frame_length < LEN_ETH_IP) begin
      early_verdict = V_DROP;
    end else if (in_data.ip_protocol == PROTO_TCP) begin
      if (in_data.frame_length < LEN_TCP_MIN) early_verdict = V_DROP;
      else early_scan = 1'b1;
    end else if (in_data.ip_protocol == PROTO_UDP) begin
      if (in_data.frame_length < LEN_UDP_MIN) early_verdict = V_DROP;
      else early_scan = 1'b1;
    end
  end

  // table writes and clearing share the write ports
  logic wr_vip_ok, wr_be_ok;
  assign wr_vip_ok = (32'(in_data.table_index) < 32'(VIP_ENTRIES));
  assign wr_be_ok  = wr_vip_ok &&
                     (32'(in_data.backend_slot) < 32'(BACKENDS_PER_VIP));

  always_comb begin
    vip_we    = 1'b0;
    vip_waddr = VAW'(in_data.table_index);
    vip_wdata.valid = in_data.entry_control[0];
    vip_wdata.addr  = in_data.dst_ip;
    vip_wdata.port  = in_data.dest_port;
    vip_wdata.proto = in_data.ip_protocol;
    vip_wdata.count = in_data.entry_control[4:1];
    vip_wdata.algo  = in_data.entry_control[6:5];
    be_we     = 1'b0;
    be_waddr  = BAW'(BAW'(in_data.table_index) * BAW'(BACKENDS_PER_VIP)
                + BAW'(in_data.backend_slot));
    be_wdata.enabled = in_data.entry_control[0];
    be_wdata.addr    = in_data.dst_ip;
    be_wdata.port    = in_data.dest_port;
    mac_wdata = in_data.entry_mac;
    if (cmd.clear) begin
      vip_we    = (32'(clr_r) < 32'(VIP_ENTRIES));
      vip_waddr = VAW'(clr_r);
      vip_wdata = '0;
      be_we     = 1'b1;
      be_waddr  = clr_r;
      be_wdata  = '0;
    end else if (cmd.load) begin
      vip_we = (in_data.operation == OP_WRITE_VIP) && wr_vip_ok;
      be_we  = (in_data.operation == OP_WRITE_BE) && wr_be_ok;
    end
  end

  // scan reads
  assign vip_re    = cmd.scan && (32'(scan_addr_r) < 32'(VIP_ENTRIES));
  assign vip_raddr = VAW'(scan_addr_r);

  logic vip_match;
  assign vip_match = rvalid_r && vip_rdata.valid &&
                     (vip_rdata.addr == item_r.dst_ip) &&
                     (vip_rdata.port == item_r.dest_port) &&
                     (vip_rdata.proto == item_r.ip_protocol);

  // hash of the source ip plus the destination port, or the source port if that is zero
  logic [31:0] hash;
  assign hash = item_r.src_ip + 32'((item_r.dest_port != 16'd0) ?
                                    item_r.dest_port : item_r.source_port);

  // one remainder step
  logic [4:0] rem_sh;
  logic [4:0] rem_sub;
  assign rem_sh  = {rem_r, div_r[31]};
  assign rem_sub = (rem_sh >= {1'b0, count_r}) ? rem_sh - {1'b0, count_r} : rem_sh;

  // backend read address
  logic idx_bad;
  assign idx_bad  = (32'(rem_r) >= 32'(BACKENDS_PER_VIP));
  assign be_re    = cmd.bread;
  assign be_raddr = BAW'(BAW'(hit_r) * BAW'(BACKENDS_PER_VIP) + BAW'(rem_r));

  // status
  always_comb begin
    st.clear_last = (32'(clr_r) == BDEPTH - 1);
    st.need_scan  = early_scan;
    st.match      = vip_match;
    st.scan_end   = rvalid_r && (32'(cmp_idx_r) == VIP_ENTRIES - 1);
    st.count_zero = (count_r == 4'd0);
    st.mod_last   = (32'(step_r) == MOD_STEPS - 1);
    st.idx_bad    = idx_bad;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      rr_r      <= '0;
      rx_r      <= '0;
      tx_r      <= '0;
      drop_r    <= '0;
      out_valid <= 1'b0;
      rvalid_r  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (cmd.load) begin
        rvalid_r <= 1'b0;
      end else if (cmd.scan) begin
        rvalid_r <= vip_re;
      end
      if (cmd.mstart && count_r != 4'd0 && algo_r == ALGO_RR) rr_r <= rr_r + 32'd1;
      // counter update and result beat
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (verdict_r == V_PASS) begin
          rx_r <= rx_r + 32'd1;
        end else if (verdict_r == V_TX) begin
          rx_r <= rx_r + 32'd1;
          tx_r <= tx_r + 32'd1;
        end else if (verdict_r == V_DROP) begin
          drop_r <= drop_r + 32'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_data;
      verdict_r   <= early_verdict;
      scan_addr_r <= '0;
      mac_r       <= '0;
      ip_r        <= '0;
      port_r      <= '0;
      chosen_r    <= '0;
    end
    if (cmd.scan) begin
      if (vip_re) scan_addr_r <= scan_addr_r + 1'b1;
      cmp_idx_r <= vip_raddr;
      if (vip_match) begin
        hit_r   <= cmp_idx_r;
        count_r <= vip_rdata.count;
        algo_r  <= vip_rdata.algo;
      end
    end
    if (cmd.mstart) begin
      div_r  <= (algo_r == ALGO_RR) ? rr_r : hash;
      rem_r  <= '0;
      step_r <= '0;
      if (count_r == 4'd0) verdict_r <= V_DROP;
    end
    if (cmd.mstep) begin
      rem_r  <= rem_sub[3:0];
      div_r  <= {div_r[30:0], 1'b0};
      step_r <= step_r + 1'b1;
    end
    if (cmd.bread && idx_bad) verdict_r <= V_DROP;
    if (cmd.bdata) begin
      if (be_rdata.enabled) begin
        verdict_r <= V_TX;
        mac_r     <= mac_rdata;
        ip_r      <= be_rdata.addr;
        port_r    <= be_rdata.port;
        chosen_r  <= rem_r[2:0];
      end else begin
        verdict_r <= V_DROP;
      end
    end
    if (cmd.finish) begin
      out_data.verdict        <= verdict_r;
      out_data.new_dst_mac    <= mac_r;
      out_data.new_dst_ip     <= ip_r;
      out_data.new_dest_port  <= port_r;
      out_data.chosen_backend <= chosen_r;
      out_data.received_count <= rx_r + 32'((verdict_r == V_PASS) || (verdict_r == V_TX));
      out_data.sent_count     <= tx_r + 32'(verdict_r == V_TX);
      out_data.dropped_count  <= drop_r + 32'(verdict_r == V_DROP);
    end
  end

  // tables
  l4lb_ram #(.WIDTH(VIP_W), .DEPTH(VIP_ENTRIES)) u_vip_ram (
    .clk(clk), .we(vip_we), .waddr(vip_waddr), .wdata(vip_wdata),
    .re(vip_re), .raddr(vip_raddr), .rdata(vip_rdata)
  );

  l4lb_ram #(.WIDTH(BE_W), .DEPTH(BDEPTH)) u_be_ram (
    .clk(clk), .we(be_we), .waddr(be_waddr), .wdata(be_wdata),
    .re(be_re), .raddr(be_raddr), .rdata(be_rdata)
  );

  l4lb_ram #(.WIDTH(MAC_W), .DEPTH(BDEPTH)) u_mac_ram (
    .clk(clk), .we(be_we && !cmd.clear), .waddr(be_waddr), .wdata(mac_wdata),
    .re(be_re), .raddr(be_raddr), .rdata(mac_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/l4_vip_load_balancer.sv =====
// l4_vip_load_balancer: top level, joins controller and datapath
// depends on l4lb_pkg, l4lb_ctrl, l4lb_dp, l4lb_ram
`default_nettype none

// Usage: one item is taken per beat when start is high and busy is low.
// An item is either a packet header (operation packet) or a table write
// (vip entry or backend entry). Each item yields exactly one result beat,
// out_valid high for one cycle with out_data; the receiver cannot stall.
// Table writes, short frames, non-ipv4 and non-tcp/udp packets go from
// accept straight to the result beat. Other packets scan the vip table, to
// the end if there is no hit; a hit with an empty backend set ends there,
// otherwise the bit-serial remainder unit picks the slot, a slot beyond the
// table ends there, and else the backend entry is read.
// The vip search reads one entry of the vip memory per cycle, lowest index
// first; the backend index comes from a one bit per cycle remainder unit.
// A new item is taken once the previous result beat has been issued.
// After reset the block runs a clearing pass over the vip and backend address
// tables (the backend mac table is not cleared), busy stays high meanwhile, and all
// counters and the round-robin counter start at zero.

module l4_vip_load_balancer #(
  parameter int VIP_ENTRIES      = l4lb_pkg::VIP_ENTRIES_DEF,
  parameter int BACKENDS_PER_VIP = l4lb_pkg::BACKENDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire l4lb_pkg::l4lb_in_t in_data,
  output logic                    out_valid,
  output l4lb_pkg::l4lb_out_t     out_data
);

  import l4lb_pkg::*;

  l4lb_cmd_t  cmd;
  l4lb_stat_t st;

  l4lb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .st(st)
  );

  l4lb_dp #(
    .VIP_ENTRIES(VIP_ENTRIES), .BACKENDS_PER_VIP(BACKENDS_PER_VIP)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .st(st),
    .out_valid(out_valid), .out_data(out_data)
  );

  // an accepted item always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result beat lands while idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");

  // result beats are single cycle
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat repeated");

  // the new destination ip stays zero unless the verdict is transmit
  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != V_TX |-> out_data.new_dst_ip == 32'd0)
    else $error("rewrite fields set without transmit");

endmodule

`default_nettype wire
